>>> rtl/sts_pkg.sv
// shared constants and types for the taylor series sine block
`timescale 1ns / 1ps

package sts_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int ANGLE_W     = 32;
   localparam int SINE_W      = 30;
   localparam int TERMS_W     = 5;
   localparam int EPS_W       = 29;
   localparam logic [EPS_W-1:0] EPS_RESET = 29'd16;

   localparam int MUL_A_W     = 36;
   localparam int MUL_B_W     = 17;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 70;

   localparam int RECIP_SHIFT = 36;
   localparam int RECIP_W     = 34;
   localparam int DIV_W       = 12;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_op_type;

endpackage

>>> rtl/sts_mul.sv
// shared registered multiplier used by the series sequencer
`timescale 1ns / 1ps

module sts_mul (
   input  logic                         clock,
   input  sts_pkg::mul_op_type          mul_op,
   output logic [sts_pkg::MUL_P_W-1:0]  mul_p
);

   logic [sts_pkg::MUL_P_W-1:0] prod_ff;
   logic [sts_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = sts_pkg::MUL_P_W'(mul_op.a) * sts_pkg::MUL_P_W'(mul_op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

>>> rtl/taylor_series_sine.sv
// taylor series sine: sequencer, term recurrence and result register
// one request at a time: req_stall holds new requests off until the sequencer is idle; each term runs
// three multiply steps on the single 36x17 multiplier (times x squared, reciprocal, check)
// a finished result waits in the output register while the next request is taken
// reset: synchronous, clears the sequencer and rsp_valid, sets epsilon to 16
`timescale 1ns / 1ps

module taylor_series_sine #(
   parameter int MAX_TERMS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sts_pkg::ANGLE_W-1:0]  req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sts_pkg::SINE_W-1:0]   rsp_sine,
   output logic [sts_pkg::TERMS_W-1:0]         rsp_terms_used,
   output logic                                rsp_truncated,
   input  logic                                csr_wr_en,
   input  logic [sts_pkg::EPS_W-1:0]           csr_wr_data
);

   localparam int NW = $clog2(MAX_TERMS + 1);
   localparam int IW = $clog2(MAX_TERMS);
   localparam int SUM_W = 35;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SQ_LO  = 4'd1;
   localparam logic [3:0] ST_SQ_HI  = 4'd2;
   localparam logic [3:0] ST_SQ_END = 4'd3;
   localparam logic [3:0] ST_ADD    = 4'd4;
   localparam logic [3:0] ST_MX_LO  = 4'd5;
   localparam logic [3:0] ST_MX_HI  = 4'd6;
   localparam logic [3:0] ST_MX_END = 4'd7;
   localparam logic [3:0] ST_DR_LO  = 4'd8;
   localparam logic [3:0] ST_DR_HI  = 4'd9;
   localparam logic [3:0] ST_DR_END = 4'd10;
   localparam logic [3:0] ST_QD     = 4'd11;
   localparam logic [3:0] ST_QD_END = 4'd12;
   localparam logic [3:0] ST_FIN    = 4'd13;

   localparam logic signed [sts_pkg::ANGLE_W-1:0] ANGLE_LIM = 32'sd1073741824;
   localparam logic signed [sts_pkg::ANGLE_W-1:0] ANGLE_NLIM = -32'sd1073741824;
   localparam logic signed [SUM_W-1:0] SUM_ONE  = 35'sd268435456;
   localparam logic signed [SUM_W-1:0] SUM_NONE = -35'sd268435456;

   // reciprocal and divisor tables for (2n)(2n+1)
   logic [sts_pkg::RECIP_W-1:0] recip_tab [MAX_TERMS];
   logic [sts_pkg::DIV_W-1:0]   div_tab   [MAX_TERMS];

   assign recip_tab[0] = '0;
   assign div_tab[0]   = '0;

   for (genvar g = 1; g < MAX_TERMS; g++) begin : g_tab
      localparam longint unsigned DV = longint'((2 * g) * (2 * g + 1));
      localparam longint unsigned RV = (64'd1 << sts_pkg::RECIP_SHIFT) / DV;
      assign recip_tab[g] = sts_pkg::RECIP_W'(RV);
      assign div_tab[g]   = sts_pkg::DIV_W'(DV);
   end

   logic [3:0]                     state_ff, state_in;
   logic [sts_pkg::EPS_W-1:0]      eps_ff, eps_in;
   logic                           neg_ff, neg_in;
   logic [30:0]                    mag_ff, mag_in;
   logic [32:0]                    x2_ff, x2_in;
   logic [31:0]                    m_ff, m_in;
   logic [35:0]                    d_ff, d_in;
   logic [33:0]                    q_ff, q_in;
   logic [sts_pkg::MUL_P_W-1:0]    lo_ff, lo_in;
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic [NW-1:0]                  n_ff, n_in;
   logic                           trunc_ff, trunc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sts_pkg::SINE_W-1:0]     sine_ff, sine_in;
   logic [sts_pkg::TERMS_W-1:0]    terms_ff, terms_in;
   logic                           trunc_out_ff, trunc_out_in;

   sts_pkg::mul_op_type            mul_op;
   logic [sts_pkg::MUL_P_W-1:0]    mul_p;
   logic [sts_pkg::ACC_W-1:0]      full;
   logic [sts_pkg::RECIP_W-1:0]    recip;
   logic [sts_pkg::DIV_W-1:0]      div;

   sts_mul u_mul (
      .clock  (clock),
      .mul_op (mul_op),
      .mul_p  (mul_p)
   );

   assign full  = sts_pkg::ACC_W'(lo_ff) + (sts_pkg::ACC_W'(mul_p) << sts_pkg::MUL_B_W);
   assign recip = recip_tab[n_ff[IW-1:0]];
   assign div   = div_tab[n_ff[IW-1:0]];

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      logic signed [SUM_W-1:0] sum_nx;
      logic signed [SUM_W-1:0] term_s;
      logic [37:0]             rem;
      logic [33:0]             q_fix;
      logic                    load;

      state_in     = state_ff;
      eps_in       = eps_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      x2_in        = x2_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      lo_in        = lo_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      trunc_in     = trunc_ff;
      sine_in      = sine_ff;
      terms_in     = terms_ff;
      trunc_out_in = trunc_out_ff;
      mul_op       = '0;
      load         = 1'b0;
      sum_nx       = '0;
      term_s       = $signed(SUM_W'(m_ff));
      rem          = '0;
      q_fix        = '0;

      if (csr_wr_en) begin
         eps_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = req_angle[sts_pkg::ANGLE_W-1];
               if (req_angle > ANGLE_LIM || req_angle < ANGLE_NLIM) begin
                  mag_in = 31'(ANGLE_LIM);
               end else if (req_angle[sts_pkg::ANGLE_W-1]) begin
                  mag_in = 31'(-req_angle);
               end else begin
                  mag_in = 31'(req_angle);
               end
               sum_in   = '0;
               n_in     = NW'(1);
               state_in = ST_SQ_LO;
            end
         end
         ST_SQ_LO: begin
            mul_op.a = sts_pkg::MUL_A_W'(mag_ff);
            mul_op.b = mag_ff[16:0];
            state_in = ST_SQ_HI;
         end
         ST_SQ_HI: begin
            mul_op.a = sts_pkg::MUL_A_W'(mag_ff);
            mul_op.b = sts_pkg::MUL_B_W'(mag_ff[30:17]);
            lo_in    = mul_p;
            state_in = ST_SQ_END;
         end
         ST_SQ_END: begin
            x2_in    = full[sts_pkg::FRAC_BITS+32:sts_pkg::FRAC_BITS];
            m_in     = 32'(mag_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_nx = neg_ff ? (sum_ff - term_s) : (sum_ff + term_s);
            sum_in = sum_nx;
            priority if (m_ff < 32'(eps_ff)) begin
               trunc_in = 1'b0;
               state_in = ST_FIN;
            end else if (n_ff == NW'(MAX_TERMS)) begin
               trunc_in = 1'b1;
               state_in = ST_FIN;
            end else begin
               state_in = ST_MX_LO;
            end
         end
         ST_MX_LO: begin
            mul_op.a = sts_pkg::MUL_A_W'(m_ff);
            mul_op.b = x2_ff[16:0];
            state_in = ST_MX_HI;
         end
         ST_MX_HI: begin
            mul_op.a = sts_pkg::MUL_A_W'(m_ff);
            mul_op.b = sts_pkg::MUL_B_W'(x2_ff[32:17]);
            lo_in    = mul_p;
            state_in = ST_MX_END;
         end
         ST_MX_END: begin
            d_in     = full[sts_pkg::FRAC_BITS+35:sts_pkg::FRAC_BITS];
            state_in = ST_DR_LO;
         end
         ST_DR_LO: begin
            mul_op.a = d_ff;
            mul_op.b = recip[16:0];
            state_in = ST_DR_HI;
         end
         ST_DR_HI: begin
            mul_op.a = d_ff;
            mul_op.b = recip[33:17];
            lo_in    = mul_p;
            state_in = ST_DR_END;
         end
         ST_DR_END: begin
            q_in     = full[sts_pkg::RECIP_SHIFT+33:sts_pkg::RECIP_SHIFT];
            state_in = ST_QD;
         end
         ST_QD: begin
            mul_op.a = sts_pkg::MUL_A_W'(q_ff);
            mul_op.b = sts_pkg::MUL_B_W'(div);
            state_in = ST_QD_END;
         end
         ST_QD_END: begin
            // estimate is low by at most one
            rem      = 38'(d_ff) - mul_p[37:0];
            q_fix    = (rem >= 38'(div)) ? (q_ff + 34'd1) : q_ff;
            m_in     = q_fix[31:0];
            neg_in   = !neg_ff;
            n_in     = NW'(n_ff + 1'b1);
            state_in = ST_ADD;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load = 1'b1;
               priority if (sum_ff > SUM_ONE) begin
                  sine_in = sts_pkg::SINE_W'(SUM_ONE);
               end else if (sum_ff < SUM_NONE) begin
                  sine_in = sts_pkg::SINE_W'(SUM_NONE);
               end else begin
                  sine_in = sts_pkg::SINE_W'(sum_ff);
               end
               terms_in     = sts_pkg::TERMS_W'(n_ff);
               trunc_out_in = trunc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eps_ff       <= sts_pkg::EPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eps_ff       <= eps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      x2_ff        <= x2_in;
      m_ff         <= m_in;
      d_ff         <= d_in;
      q_ff         <= q_in;
      lo_ff        <= lo_in;
      sum_ff       <= sum_in;
      n_ff         <= n_in;
      trunc_ff     <= trunc_in;
      sine_ff      <= sine_in;
      terms_ff     <= terms_in;
      trunc_out_ff <= trunc_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sine       = $signed(sine_ff);
   assign rsp_terms_used = terms_ff;
   assign rsp_truncated  = trunc_out_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SQ_LO))
      else $error("accepted request did not start the square pass");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sine <= 30'sd268435456 && rsp_sine >= -30'sd268435456))
      else $error("sine outside saturation range");

   a_trunc_terms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |-> (rsp_terms_used == sts_pkg::TERMS_W'(MAX_TERMS)))
      else $error("truncated result without full term count");

   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (n_ff != '0 && n_ff <= NW'(MAX_TERMS)))
      else $error("term index out of range");

endmodule
